// File: rtl/core/kpg_pkg.sv
// ----------------------------------------------------------------------------
// kpg_pkg
// Shared widths, register indexes and the cell control bundle of the
// k-permutation generator.
// ----------------------------------------------------------------------------
package kpg_pkg;

  // tuple positions held by the cell ring (one cell per position)
  localparam int NUM_POS = 8;
  localparam int IDX_W   = $clog2(NUM_POS);
  // width of one tuple value and of each configuration register
  localparam int VAL_W   = 4;
  // configuration write index width (leaves room for unmapped indexes)
  localparam int CFG_IDX_W = 2;
  // default size of the value set
  localparam int DEF_MAX_VALUES = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_N_VALUES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = CFG_IDX_W'(1);

  // control bundle driven to every cell of the ring
  typedef struct packed {
    logic clear;  // zero the cell
    logic up;     // take the value of the next cell (ring turns toward higher positions)
    logic dn;     // take the value of the previous cell
  } cell_ctl_t;

endpackage

// File: rtl/core/kpg_if.sv
// ----------------------------------------------------------------------------
// kpg_if
// Valid/ready channels of the k-permutation generator: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface kpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface kpg_res_if;
  logic                    valid;
  logic                    ready;
  logic [kpg_pkg::VAL_W-1:0] pos0;
  logic [kpg_pkg::VAL_W-1:0] pos1;
  logic [kpg_pkg::VAL_W-1:0] pos2;
  logic [kpg_pkg::VAL_W-1:0] pos3;
  logic [kpg_pkg::VAL_W-1:0] pos4;
  logic [kpg_pkg::VAL_W-1:0] pos5;
  logic [kpg_pkg::VAL_W-1:0] pos6;
  logic [kpg_pkg::VAL_W-1:0] pos7;
  logic                    tuple_valid;
  logic                    last_tuple;

  modport source (output valid, output pos0, output pos1, output pos2, output pos3,
                  output pos4, output pos5, output pos6, output pos7,
                  output tuple_valid, output last_tuple, input ready);
  modport sink   (input valid, input pos0, input pos1, input pos2, input pos3,
                  input pos4, input pos5, input pos6, input pos7,
                  input tuple_valid, input last_tuple, output ready);
endinterface

interface kpg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kpg_pkg::CFG_IDX_W-1:0] index;
  logic [kpg_pkg::VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/kpg_cell.sv
// ----------------------------------------------------------------------------
// kpg_cell
// One cell of the tuple ring: holds one tuple value and takes a neighbor's
// value whenever the ring turns.
// ----------------------------------------------------------------------------
module kpg_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kpg_pkg::cell_ctl_t        ctl,
  input  logic [kpg_pkg::VAL_W-1:0] from_next,
  input  logic [kpg_pkg::VAL_W-1:0] from_prev,
  output logic [kpg_pkg::VAL_W-1:0] value
);
  import kpg_pkg::*;

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;

  // clear wins, then turn in either direction
  always_comb begin
    value_nxt = value_r;
    if (ctl.clear) begin
      value_nxt = '0;
    end else if (ctl.up) begin
      value_nxt = from_next;
    end else if (ctl.dn) begin
      value_nxt = from_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

// File: rtl/core/k_permutation_generator.sv
// ----------------------------------------------------------------------------
// k_permutation_generator
// Lexicographic k-permutation generator built on a ring of value cells.
// ----------------------------------------------------------------------------
// Each request returns one ordered tuple of pick_count distinct values from
// 1..n_values (n_values capped at MAX_VALUES), in lexicographic order;
// restart (or the first request after reset or a register write) gives the
// first tuple. The tuple lives in a ring of eight cells that turns one step
// per cycle; a controller edits the head cell and keeps the used-value mask.
// A restart runs one fill step per position, then an end check and the
// issue. A next request runs an alignment step, one step per position
// scanned back from the right end, one fill step per position refilled after
// it, an end check and the issue. Once the final tuple has been flagged, or
// when no tuple exists, further requests answer "no tuple" until a restart.
// The issue cycle is held while the output register still holds a result
// that has not been taken. A new request is taken once the previous one has
// issued, even while its result still waits in the output register.
// ----------------------------------------------------------------------------
module k_permutation_generator #(
  parameter int MAX_VALUES = kpg_pkg::DEF_MAX_VALUES
) (
  input  logic clk,
  input  logic rst_n,
  kpg_req_if.sink   in_req,
  kpg_res_if.source out_res,
  kpg_cfg_if.sink   cfg_wr
);
  import kpg_pkg::*;

  // controller states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [VAL_W-1:0] MAXV = VAL_W'(MAX_VALUES);

  logic [2:0]            state_r, state_nxt;
  logic [VAL_W-1:0]      pos_r, pos_nxt;        // logical position at the head cell
  logic [MAX_VALUES-1:0] mask_r, mask_nxt;
  logic                  started_r, started_nxt;
  logic                  exhausted_r, exhausted_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic [VAL_W-1:0]      n_raw_r, n_raw_nxt;
  logic [VAL_W-1:0]      k_r, k_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_tv_r, out_tv_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [VAL_W-1:0]      out_pos_r   [NUM_POS];
  logic [VAL_W-1:0]      out_pos_nxt [NUM_POS];

  cell_ctl_t             ctl;
  logic [VAL_W-1:0]      cell_q  [NUM_POS];
  logic [VAL_W-1:0]      link    [NUM_POS];
  logic [VAL_W-1:0]      view    [NUM_POS];
  logic [VAL_W-1:0]      head_val;

  logic [VAL_W-1:0]      eff_n;
  logic                  in_acc;
  logic                  cfg_acc;
  logic                  out_free;
  logic [VAL_W-1:0]      lo;
  logic                  found;
  logic [VAL_W-1:0]      found_val;
  logic [MAX_VALUES-1:0] cur_bit;
  logic [MAX_VALUES-1:0] found_bit;
  logic                  last_c;

  assign eff_n    = (n_raw_r > MAXV) ? MAXV : n_raw_r;
  assign in_acc   = in_req.valid && in_req.ready;
  assign cfg_acc  = cfg_wr.valid && cfg_wr.ready;
  assign out_free = !out_valid_r || out_res.ready;

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;

  // ring of cells; the head cell's outgoing value is replaced by the edit
  always_comb begin
    for (int i = 0; i < NUM_POS; i++) begin
      link[i] = cell_q[i];
    end
    link[0] = head_val;
  end

  for (genvar g = 0; g < NUM_POS; g++) begin : g_cell
    localparam int UP = (g + 1) % NUM_POS;
    localparam int DN = (g + NUM_POS - 1) % NUM_POS;
    kpg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .from_next (link[UP]),
      .from_prev (link[DN]),
      .value     (cell_q[g])
    );
  end

  // logical view of the tuple: position p sits in cell (p - head position)
  always_comb begin
    for (int p = 0; p < NUM_POS; p++) begin
      view[p] = cell_q[IDX_W'(p) - pos_r[IDX_W-1:0]];
    end
  end

  // smallest free value above lo and not above n
  assign lo = (state_r == ST_SCAN) ? cell_q[0] : '0;
  always_comb begin
    found     = 1'b0;
    found_val = '0;
    found_bit = '0;
    cur_bit   = '0;
    for (int i = MAX_VALUES - 1; i >= 0; i--) begin
      if (!mask_r[i] && (VAL_W'(i + 1) > lo) && (VAL_W'(i + 1) <= eff_n)) begin
        found     = 1'b1;
        found_val = VAL_W'(i + 1);
        found_bit = MAX_VALUES'(1) << i;
      end
    end
    for (int i = 0; i < MAX_VALUES; i++) begin
      cur_bit[i] = (cell_q[0] == VAL_W'(i + 1));
    end
  end

  // final tuple is n, n-1, ... down the positions
  always_comb begin
    last_c = 1'b1;
    for (int p = 0; p < NUM_POS; p++) begin
      if ((VAL_W'(p) < k_r) && (view[p] != (eff_n - VAL_W'(p)))) begin
        last_c = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    mask_nxt      = mask_r;
    started_nxt   = started_r;
    exhausted_nxt = exhausted_r;
    res_valid_nxt = res_valid_r;
    n_raw_nxt     = n_raw_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_tv_nxt    = out_tv_r;
    out_last_nxt  = out_last_r;
    out_pos_nxt   = out_pos_r;
    ctl           = '0;
    head_val      = cell_q[0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.restart || !started_r) begin
            started_nxt   = 1'b1;
            exhausted_nxt = 1'b0;
            ctl.clear     = 1'b1;
            mask_nxt      = '0;
            pos_nxt       = '0;
            if (k_r > eff_n) begin
              exhausted_nxt = 1'b1;
              res_valid_nxt = 1'b0;
              state_nxt     = ST_DONE;
            end else begin
              res_valid_nxt = 1'b1;
              state_nxt     = ST_FILL;
            end
          end else if (exhausted_r) begin
            res_valid_nxt = 1'b0;
            state_nxt     = ST_DONE;
          end else begin
            res_valid_nxt = 1'b1;
            state_nxt     = ST_ALIGN;
          end
        end
      end
      ST_FILL: begin
        if (pos_r == k_r) begin
          state_nxt = ST_DONE;
        end else begin
          head_val = found_val;
          mask_nxt = mask_r | found_bit;
          ctl.up   = 1'b1;
          pos_nxt  = pos_r + VAL_W'(1);
        end
      end
      ST_ALIGN: begin
        ctl.dn    = 1'b1;
        pos_nxt   = pos_r - VAL_W'(1);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (found) begin
          head_val  = found_val;
          mask_nxt  = (mask_r & ~cur_bit) | found_bit;
          ctl.up    = 1'b1;
          pos_nxt   = pos_r + VAL_W'(1);
          state_nxt = ST_FILL;
        end else begin
          head_val = '0;
          mask_nxt = mask_r & ~cur_bit;
          if (pos_r == '0) begin
            // no successor: enumeration ends
            exhausted_nxt = 1'b1;
            res_valid_nxt = 1'b0;
            ctl.clear     = 1'b1;
            mask_nxt      = '0;
            state_nxt     = ST_DONE;
          end else begin
            ctl.dn  = 1'b1;
            pos_nxt = pos_r - VAL_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tv_nxt    = res_valid_r;
          out_last_nxt  = res_valid_r && last_c;
          for (int p = 0; p < NUM_POS; p++) begin
            out_pos_nxt[p] = res_valid_r ? view[p] : '0;
          end
          if (res_valid_r && last_c) begin
            exhausted_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes restart the enumeration
    if (cfg_acc) begin
      unique case (cfg_wr.index)
        REG_N_VALUES: begin
          n_raw_nxt     = cfg_wr.data;
          started_nxt   = 1'b0;
          exhausted_nxt = 1'b0;
        end
        REG_PICK_COUNT: begin
          k_nxt         = cfg_wr.data;
          started_nxt   = 1'b0;
          exhausted_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      mask_r      <= '0;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      res_valid_r <= 1'b0;
      n_raw_r     <= VAL_W'(4);
      k_r         <= VAL_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      mask_r      <= mask_nxt;
      started_r   <= started_nxt;
      exhausted_r <= exhausted_nxt;
      res_valid_r <= res_valid_nxt;
      n_raw_r     <= n_raw_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_tv_r   <= out_tv_nxt;
    out_last_r <= out_last_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.tuple_valid = out_tv_r;
  assign out_res.last_tuple  = out_last_r;
  assign out_res.pos0        = out_pos_r[0];
  assign out_res.pos1        = out_pos_r[1];
  assign out_res.pos2        = out_pos_r[2];
  assign out_res.pos3        = out_pos_r[3];
  assign out_res.pos4        = out_pos_r[4];
  assign out_res.pos5        = out_pos_r[5];
  assign out_res.pos6        = out_pos_r[6];
  assign out_res.pos7        = out_pos_r[7];

endmodule
